@@ sv/nrsx_pkg.sv @@
// Package with the item types, command codes and register indexes of the NRPN forwarder.
`default_nettype none
package nrsx_pkg;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_NRPN = 2'd1;
  localparam logic [1:0] CMD_KNOB = 2'd2;

  localparam logic [1:0] CFG_HOLDOFF_TICKS   = 2'd0;
  localparam logic [1:0] CFG_ID_PARAM_NUMBER = 2'd1;
  localparam logic [1:0] CFG_HIGHEST_PARAM   = 2'd2;

  localparam int CfgDataW = 14;

  localparam logic [7:0] RST_HOLDOFF_TICKS = 8'd10;
  localparam logic [13:0] RST_ID_PARAM     = 14'd1024;
  localparam logic [13:0] RST_HIGHEST      = 14'd382;

  localparam int MsgLen = 10;
  localparam int MsgIdxW = $clog2(MsgLen);

  localparam int FifoDepth = 2;
  localparam int FifoPtrW = $clog2(FifoDepth);
  localparam int FifoCntW = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [13:0] param_number;
    logic [13:0] param_value;
    logic [9:0]  knob_level;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic [6:0]  id;
    logic [13:0] number;
    logic [6:0]  value;
  } msg_t;

endpackage
`default_nettype wire

@@ sv/nrsx_front.sv @@
// Front end: accepts items, keeps the holdoff counter, device id and holding slot.
`default_nettype none
module nrsx_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire nrsx_pkg::in_t in_data,
  input  wire logic          cfg_valid,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [nrsx_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic          q_full,
  output logic               q_push,
  output nrsx_pkg::msg_t     q_data
);
  import nrsx_pkg::*;

  logic [7:0]  holdoff_ticks_r;
  logic [13:0] id_param_r;
  logic [13:0] highest_r;
  logic [7:0]  count_r, count_nxt;
  logic [6:0]  device_id_r, device_id_nxt;
  logic        slot_full_r, slot_full_nxt;
  msg_t        held_r, held_nxt;
  logic        accept;
  logic [7:0]  count_dec;
  logic [6:0]  val7;

  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign count_dec = (count_r != 8'd0) ? count_r - 8'd1 : 8'd0;
  assign val7      = in_data.param_value[13:7];

  always_comb begin
    count_nxt     = count_r;
    device_id_nxt = device_id_r;
    slot_full_nxt = slot_full_r;
    held_nxt      = held_r;
    q_push        = 1'b0;
    q_data        = '{id: device_id_r, number: in_data.param_number, value: val7};
    if (accept) begin
      unique case (in_data.cmd)
        CMD_TICK: begin
          count_nxt = count_dec;
          q_data    = held_r;
          if (count_dec == 8'd0 && slot_full_r) begin
            slot_full_nxt = 1'b0;
            q_push        = 1'b1;
            count_nxt     = holdoff_ticks_r;
          end
        end
        CMD_NRPN: begin
          if (in_data.param_number == id_param_r) begin
            device_id_nxt = val7;
          end else if (in_data.param_number <= highest_r) begin
            if (count_r != 8'd0) begin
              held_nxt      = q_data;
              slot_full_nxt = 1'b1;
            end else begin
              q_push    = 1'b1;
              count_nxt = holdoff_ticks_r;
            end
          end
        end
        CMD_KNOB: begin
          device_id_nxt = {3'd0, in_data.knob_level[9:6]};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_ticks_r <= RST_HOLDOFF_TICKS;
      id_param_r      <= RST_ID_PARAM;
      highest_r       <= RST_HIGHEST;
      count_r         <= 8'd0;
      device_id_r     <= 7'd0;
      slot_full_r     <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      device_id_r <= device_id_nxt;
      slot_full_r <= slot_full_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_HOLDOFF_TICKS:   holdoff_ticks_r <= cfg_data[7:0];
          CFG_ID_PARAM_NUMBER: id_param_r      <= cfg_data[13:0];
          CFG_HIGHEST_PARAM:   highest_r       <= cfg_data[13:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule
`default_nettype wire

@@ sv/nrsx_fifo.sv @@
// Short message queue between the front end and the byte serializer.
`default_nettype none
module nrsx_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire nrsx_pkg::msg_t push_data,
  input  wire logic           pop,
  output nrsx_pkg::msg_t      pop_data,
  output logic                full,
  output logic                empty
);
  import nrsx_pkg::*;

  msg_t                mem_r [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FifoCntW-1:0] count_r;
  logic                do_push, do_pop;

  assign full     = (count_r == FifoCntW'(FifoDepth));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/nrsx_back.sv @@
// Back end: turns each queued message into ten framed system-exclusive bytes.
`default_nettype none
module nrsx_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire nrsx_pkg::msg_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output nrsx_pkg::out_t      out_data
);
  import nrsx_pkg::*;

  msg_t               msg_r;
  logic               busy_r;
  logic [MsgIdxW-1:0] idx_r;
  logic               take, last;

  assign out_valid = busy_r;
  assign take      = busy_r && !out_stall;
  assign last      = (idx_r == MsgIdxW'(MsgLen - 1));
  assign q_pop     = !q_empty && (!busy_r || (take && last));

  always_comb begin
    out_data.last_byte = last;
    unique case (idx_r)
      4'd0:    out_data.out_byte = 8'hF0;
      4'd1:    out_data.out_byte = 8'h3E;
      4'd2:    out_data.out_byte = 8'h13;
      4'd3:    out_data.out_byte = {1'b0, msg_r.id};
      4'd4:    out_data.out_byte = 8'h20;
      4'd5:    out_data.out_byte = 8'h00;
      4'd6:    out_data.out_byte = {1'b0, msg_r.number[13:7]};
      4'd7:    out_data.out_byte = {1'b0, msg_r.number[6:0]};
      4'd8:    out_data.out_byte = {1'b0, msg_r.value};
      4'd9:    out_data.out_byte = 8'hF7;
      default: out_data.out_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      msg_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (take) begin
      if (last) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/nrpn_to_sysex_rate_limiter.sv @@
// Top level of the NRPN to system-exclusive forwarder with transmit holdoff.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_stall   in_data (cmd, param_number, param_value, knob_level)
//   out      out_valid / out_stall out_data (out_byte, last_byte)
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// The front end takes one item per cycle while the queue is not full; a sent message is ten output bytes.
// The output rate is set by the serializer, one byte per cycle while out_stall is low.
// The input stalls only while the two-entry message queue is full.
// Reset is synchronous and clears the counter, id, slot, queue and serializer.
// Configuration writes are always ready and take effect on the next cycle.
`default_nettype none
module nrpn_to_sysex_rate_limiter (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire nrsx_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output nrsx_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [nrsx_pkg::CfgDataW-1:0] cfg_data
);
  import nrsx_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  msg_t q_in, q_out;

  assign cfg_ready = 1'b1;

  nrsx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  nrsx_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  nrsx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ sv/nrsx_checker.sv @@
// Port-level checker for the forwarder, bound to the top level.
`default_nettype none
module nrsx_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire nrsx_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output item changed.");

  a_last_is_f7: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_byte |-> out_data.out_byte == 8'hF7)
    else $error("Closing item is not F7.");

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_byte |=>
      !out_valid || out_data.out_byte == 8'hF0)
    else $error("Message does not start with F0.");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_byte |=> out_valid)
    else $error("Gap inside a message.");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("Reset did not clear the channels.");

endmodule

bind nrpn_to_sysex_rate_limiter nrsx_checker u_nrsx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the NRPN to system-exclusive forwarder with transmit holdoff.
`default_nettype none
module testbench;
  import nrsx_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic [7:0] SX_START = 8'hF0;
  localparam logic [7:0] SX_MAKER = 8'h3E;
  localparam logic [7:0] SX_MODEL = 8'h13;
  localparam logic [7:0] SX_DUMP  = 8'h20;
  localparam logic [7:0] SX_BANK  = 8'h00;
  localparam logic [7:0] SX_END   = 8'hF7;

  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT   = 2000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  nrpn_to_sysex_rate_limiter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  logic [7:0]  holdoff_reload;
  logic [13:0] id_number;
  logic [13:0] highest_number;
  logic [7:0]  holdoff_left;
  logic [6:0]  device_id;
  logic        slot_full;
  logic [13:0] held_number;
  logic [6:0]  held_value;
  logic [6:0]  held_id;

  out_t expected_bytes[$];
  int   err_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   idle_cycles = 0;

  function automatic void queue_message(logic [6:0] id, logic [13:0] number,
                                        logic [6:0] value);
    logic [7:0] msg [MsgLen];
    out_t       b;
    msg[0] = SX_START;
    msg[1] = SX_MAKER;
    msg[2] = SX_MODEL;
    msg[3] = {1'b0, id};
    msg[4] = SX_DUMP;
    msg[5] = SX_BANK;
    msg[6] = {1'b0, number[13:7]};
    msg[7] = {1'b0, number[6:0]};
    msg[8] = {1'b0, value};
    msg[9] = SX_END;
    for (int i = 0; i < MsgLen; i++) begin
      b.out_byte = msg[i];
      b.last_byte = (i == MsgLen - 1);
      expected_bytes.push_back(b);
    end
    holdoff_left = holdoff_reload;
  endfunction

  function automatic void predict_forwarder(in_t it);
    logic [6:0] val;
    val = it.param_value[13:7];
    case (it.cmd)
      CMD_TICK: begin
        if (holdoff_left != 8'd0) holdoff_left = holdoff_left - 8'd1;
        if (holdoff_left == 8'd0 && slot_full) begin
          slot_full = 1'b0;
          queue_message(held_id, held_number, held_value);
        end
      end
      CMD_NRPN: begin
        if (it.param_number == id_number) begin
          device_id = val;
        end else if (it.param_number <= highest_number) begin
          if (holdoff_left != 8'd0) begin
            held_id = device_id;
            held_number = it.param_number;
            held_value = val;
            slot_full = 1'b1;
          end else begin
            queue_message(device_id, it.param_number, val);
          end
        end
      end
      CMD_KNOB: device_id = {3'b000, it.knob_level[9:6]};
      default: ;
    endcase
  endfunction

  function automatic in_t item_of(logic [1:0] cmd, logic [13:0] number,
                                  logic [13:0] value, logic [9:0] knob);
    in_t it;
    it.cmd = cmd;
    it.param_number = number;
    it.param_value = value;
    it.knob_level = knob;
    return it;
  endfunction

  function automatic in_t random_item();
    in_t it;
    int  r;
    it = item_of(CMD_TICK, 14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                 10'($urandom_range(0, 1023)));
    r = $urandom_range(0, 99);
    if (r < 35) begin
      it.cmd = CMD_TICK;
    end else if (r < 75) begin
      it.cmd = CMD_NRPN;
      it.param_number = 14'($urandom_range(0, highest_number));
    end else if (r < 83) begin
      it.cmd = CMD_NRPN;
      it.param_number = id_number;
    end else if (r < 90) begin
      it.cmd = CMD_NRPN;
    end else if (r < 97) begin
      it.cmd = CMD_KNOB;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    predict_forwarder(it);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [CfgDataW-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_HOLDOFF_TICKS:   holdoff_reload = data[7:0];
      CFG_ID_PARAM_NUMBER: id_number = data;
      CFG_HIGHEST_PARAM:   highest_number = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(logic [7:0] holdoff, logic [13:0] idn, logic [13:0] highest);
    settle();
    write_reg(CFG_HOLDOFF_TICKS, {6'($urandom_range(0, 63)), holdoff});
    write_reg(CFG_ID_PARAM_NUMBER, idn);
    write_reg(CFG_HIGHEST_PARAM, highest);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 14'($urandom_range(0, 16383)));
    cfg_valid = 1'b0;
  endtask

  task automatic test_holdoff_and_slot();
    send_item(item_of(CMD_UNUSED, 14'h3FFF, 14'h3FFF, 10'h3FF));
    send_item(item_of(CMD_NRPN, 14'd0, 14'h3FFF, 10'd0));
    send_item(item_of(CMD_KNOB, 14'h3FFF, 14'd0, 10'h3FF));
    send_item(item_of(CMD_KNOB, 14'd0, 14'h3FFF, 10'd0));
    send_item(item_of(CMD_NRPN, RST_ID_PARAM, 14'h3FFF, 10'd0));
    send_item(item_of(CMD_NRPN, RST_HIGHEST, 14'd0, 10'h3FF));
    send_item(item_of(CMD_NRPN, RST_HIGHEST + 14'd1, 14'h3FFF, 10'd0));
    send_item(item_of(CMD_NRPN, 14'h3FFF, 14'h3FFF, 10'd0));
    send_item(item_of(CMD_NRPN, 14'd100, 14'd5000, 10'd0));
    repeat (11) send_item(item_of(CMD_TICK, 14'($urandom_range(0, 16383)),
                                  14'($urandom_range(0, 16383)),
                                  10'($urandom_range(0, 1023))));
  endtask

  task automatic test_zero_holdoff();
    set_config(8'd0, 14'd5, 14'h3FFF);
    send_item(item_of(CMD_NRPN, 14'd5, 14'd8191, 10'd0));
    send_item(item_of(CMD_NRPN, 14'h3FFF, 14'd12345, 10'd0));
    send_item(item_of(CMD_NRPN, 14'd0, 14'd0, 10'd0));
    send_item(item_of(CMD_TICK, 14'd0, 14'd0, 10'd0));
  endtask

  task automatic test_wide_holdoff();
    set_config(8'd255, 14'h3FFF, 14'd0);
    send_item(item_of(CMD_NRPN, 14'd0, 14'h2AAA, 10'd0));
    send_item(item_of(CMD_NRPN, 14'd0, 14'h1555, 10'd0));
    send_item(item_of(CMD_NRPN, 14'h3FFF, 14'h1555, 10'd0));
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct);
    logic [7:0]  holdoff;
    logic [13:0] highest;
    logic [13:0] idn;
    int          r;
    for (int k = 0; k < 2; k++) begin
      r = $urandom_range(0, 9);
      holdoff = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 4));
      r = $urandom_range(0, 5);
      highest = (r == 0) ? 14'd0 : (r == 1) ? 14'h3FFF : 14'($urandom_range(0, 16383));
      idn = ($urandom_range(0, 1) == 0) ? 14'($urandom_range(0, highest))
                                        : 14'($urandom_range(0, 16383));
      set_config(holdoff, idn, highest);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (25) send_item(random_item());
    end
  endtask

  always @(negedge clk) out_stall = ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk) begin : check_result
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected item: out_byte %h last_byte %b",
               out_data.out_byte, out_data.last_byte);
        err_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_data.out_byte);
          err_count++;
        end
        if (out_data.last_byte !== want.last_byte) begin
          $error("last_byte: expected %b, actual %b", want.last_byte, out_data.last_byte);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    holdoff_reload = RST_HOLDOFF_TICKS;
    id_number = RST_ID_PARAM;
    highest_number = RST_HIGHEST;
    holdoff_left = '0;
    device_id = '0;
    slot_full = 1'b0;
    held_number = '0;
    held_value = '0;
    held_id = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_holdoff_and_slot();
    test_zero_holdoff();
    test_wide_holdoff();
    test_random_traffic(0, 0);
    test_random_traffic(46, 0);
    test_random_traffic(0, 46);
    test_random_traffic(34, 34);
    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
